@@ rtl/core/complex_spectrum_divide_top_defines.svh @@
// Assertion macros for the spectrum divider.
`ifndef COMPLEX_SPECTRUM_DIVIDE_TOP_DEFINES_SVH
`define COMPLEX_SPECTRUM_DIVIDE_TOP_DEFINES_SVH

`ifndef SYNTH
`define CSD_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
`define CSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");
`else
`define CSD_ASSERT_IMPLIES(label, ante, cons)
`define CSD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/csd_pkg.sv @@
package csd_pkg;

    localparam int FIELD_W = 32;
    localparam int EPS_W   = 32;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_CONJ_MODE = 2'd0;
    localparam logic [IDX_W-1:0] REG_EPSILON   = 2'd1;
    localparam logic [EPS_W-1:0] EPS_RESET     = 32'd1;

    typedef struct packed {
        logic signed [FIELD_W-1:0] a_real;
        logic signed [FIELD_W-1:0] a_imag;
        logic signed [FIELD_W-1:0] b_real;
        logic signed [FIELD_W-1:0] b_imag;
        logic                      real_only;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_W-1:0] q_real;
        logic signed [FIELD_W-1:0] q_imag;
        logic                      saturated;
    } t_out_item;

    typedef struct packed {
        logic real_only;
        logic neg_re;
        logic neg_im;
        logic nneg_re;
        logic nneg_im;
        logic den_zero;
        logic nz_re;
        logic nz_im;
        logic ovf_re;
        logic ovf_im;
    } t_flags;

endpackage

@@ rtl/core/csd_front.sv @@
module csd_front #(
    parameter int SW = 32,
    parameter int FB = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  csd_pkg::t_in_item         i_item,
    input  logic                      i_conj,
    input  logic [csd_pkg::EPS_W-1:0] i_eps,
    output logic                      o_valid,
    output csd_pkg::t_flags           o_flags,
    output logic [2*SW:0]             o_den,
    output logic [2*SW:0]             o_rem_re,
    output logic [2*SW:0]             o_rem_im,
    output logic [SW-1:0]             o_low_re,
    output logic [SW-1:0]             o_low_im
);
    localparam int NW = 2 * SW;
    localparam int DW = 2 * SW + 1;
    localparam int XW = NW + FB;
    localparam int RW = SW + FB;
    localparam int CW = (RW > DW) ? RW : DW;
    localparam int EW = csd_pkg::EPS_W;

    logic signed [SW-1:0] ar, ai, br, bi;

    logic                 r_v1;
    logic signed [NW-1:0] r_p_rr, r_p_ii, r_p_ir, r_p_ri, r_br2, r_bi2;
    logic signed [SW-1:0] r_ar1, r_br1;
    logic                 r_ro1, r_conj1;
    logic [EW-1:0]        r_eps1;

    logic signed [NW:0]   s_re, s_im;
    logic signed [NW+1:0] d_ro;
    logic [NW:0]          m_re, m_im, m_ar;
    logic [NW+1:0]        m_d;
    logic [NW-1:0]        n_num_re, n_num_im;
    logic [DW-1:0]        n_den;
    logic                 n_nneg_re, n_nneg_im, n_den_neg;

    logic                 r_v2, r_ro2, r_nneg_re, r_nneg_im, r_den_neg;
    logic [NW-1:0]        r_num_re, r_num_im;
    logic [DW-1:0]        r_den2;

    logic [XW-1:0]        x_re, x_im;
    logic [CW-1:0]        r0_re, r0_im, den_c;

    assign ar = i_item.a_real[SW-1:0];
    assign ai = i_item.a_imag[SW-1:0];
    assign br = i_item.b_real[SW-1:0];
    assign bi = i_item.b_imag[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_p_rr  <= ar * br;
        r_p_ii  <= ai * bi;
        r_p_ir  <= ai * br;
        r_p_ri  <= ar * bi;
        r_br2   <= br * br;
        r_bi2   <= bi * bi;
        r_ar1   <= ar;
        r_br1   <= br;
        r_ro1   <= i_item.real_only;
        r_conj1 <= i_conj;
        r_eps1  <= i_eps;
    end

    always_comb begin
        if (r_conj1) begin
            s_re = {r_p_rr[NW-1], r_p_rr} - {r_p_ii[NW-1], r_p_ii};
            s_im = {r_p_ir[NW-1], r_p_ir} + {r_p_ri[NW-1], r_p_ri};
        end else begin
            s_re = {r_p_rr[NW-1], r_p_rr} + {r_p_ii[NW-1], r_p_ii};
            s_im = {r_p_ir[NW-1], r_p_ir} - {r_p_ri[NW-1], r_p_ri};
        end
        d_ro = (NW+2)'(r_br1) + $signed({{(NW+2-EW){1'b0}}, r_eps1});
        m_re = s_re[NW] ? (~s_re + 1'b1) : s_re;
        m_im = s_im[NW] ? (~s_im + 1'b1) : s_im;
        m_ar = r_ar1[SW-1] ? (~(NW+1)'(r_ar1) + 1'b1) : (NW+1)'(r_ar1);
        m_d  = d_ro[NW+1] ? (~d_ro + 1'b1) : d_ro;
        if (r_ro1) begin
            n_num_re  = m_ar[NW-1:0];
            n_nneg_re = r_ar1[SW-1];
            n_num_im  = '0;
            n_nneg_im = 1'b0;
            n_den     = m_d[DW-1:0];
            n_den_neg = d_ro[NW+1];
        end else begin
            n_num_re  = m_re[NW-1:0];
            n_nneg_re = s_re[NW];
            n_num_im  = m_im[NW-1:0];
            n_nneg_im = s_im[NW];
            n_den     = {1'b0, r_br2} + {1'b0, r_bi2} + {{(DW-EW){1'b0}}, r_eps1};
            n_den_neg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_ro2     <= r_ro1;
        r_num_re  <= n_num_re;
        r_num_im  <= n_num_im;
        r_nneg_re <= n_nneg_re;
        r_nneg_im <= n_nneg_im;
        r_den2    <= n_den;
        r_den_neg <= n_den_neg;
    end

    always_comb begin
        x_re  = {r_num_re, {FB{1'b0}}};
        x_im  = {r_num_im, {FB{1'b0}}};
        r0_re = CW'(x_re[XW-1:SW]);
        r0_im = CW'(x_im[XW-1:SW]);
        den_c = CW'(r_den2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v2;
        end
        o_flags.real_only <= r_ro2;
        o_flags.neg_re    <= r_nneg_re ^ r_den_neg;
        o_flags.neg_im    <= r_nneg_im;
        o_flags.nneg_re   <= r_nneg_re;
        o_flags.nneg_im   <= r_nneg_im;
        o_flags.den_zero  <= (r_den2 == '0);
        o_flags.nz_re     <= (r_num_re == '0);
        o_flags.nz_im     <= (r_num_im == '0);
        o_flags.ovf_re    <= (r0_re >= den_c);
        o_flags.ovf_im    <= (r0_im >= den_c);
        o_den    <= r_den2;
        o_rem_re <= r0_re[DW-1:0];
        o_rem_im <= r0_im[DW-1:0];
        o_low_re <= x_re[SW-1:0];
        o_low_im <= x_im[SW-1:0];
    end

endmodule

@@ rtl/core/csd_div_stage.sv @@
module csd_div_stage #(
    parameter int SW = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  csd_pkg::t_flags i_flags,
    input  logic [2*SW:0]   i_den,
    input  logic [2*SW:0]   i_rem_re,
    input  logic [2*SW:0]   i_rem_im,
    input  logic [SW-1:0]   i_low_re,
    input  logic [SW-1:0]   i_low_im,
    input  logic [SW-1:0]   i_q_re,
    input  logic [SW-1:0]   i_q_im,
    output logic            o_valid,
    output csd_pkg::t_flags o_flags,
    output logic [2*SW:0]   o_den,
    output logic [2*SW:0]   o_rem_re,
    output logic [2*SW:0]   o_rem_im,
    output logic [SW-1:0]   o_low_re,
    output logic [SW-1:0]   o_low_im,
    output logic [SW-1:0]   o_q_re,
    output logic [SW-1:0]   o_q_im
);
    localparam int DW = 2 * SW + 1;

    logic [DW:0]   t_re, t_im, d_ext, df_re, df_im;
    logic          ge_re, ge_im;
    logic [DW-1:0] n_rem_re, n_rem_im;

    always_comb begin
        t_re  = {i_rem_re, i_low_re[SW-1]};
        t_im  = {i_rem_im, i_low_im[SW-1]};
        d_ext = {1'b0, i_den};
        ge_re = (t_re >= d_ext);
        ge_im = (t_im >= d_ext);
        df_re = t_re - d_ext;
        df_im = t_im - d_ext;
        n_rem_re = ge_re ? df_re[DW-1:0] : t_re[DW-1:0];
        n_rem_im = ge_im ? df_im[DW-1:0] : t_im[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
        o_flags  <= i_flags;
        o_den    <= i_den;
        o_rem_re <= n_rem_re;
        o_rem_im <= n_rem_im;
        o_low_re <= {i_low_re[SW-2:0], 1'b0};
        o_low_im <= {i_low_im[SW-2:0], 1'b0};
        o_q_re   <= {i_q_re[SW-2:0], ge_re};
        o_q_im   <= {i_q_im[SW-2:0], ge_im};
    end

endmodule

@@ rtl/core/complex_spectrum_divide_top.sv @@
// Element-wise complex spectrum divider, Q(SAMPLE_WIDTH-FRACTION_BITS).FRACTION_BITS.
// One transaction per clock: busy is always low, so start may be held high
// every cycle. Each result appears on o_result with o_done high for exactly
// one cycle, in order; it cannot be stalled. The restoring divider resolves
// one quotient bit per pipeline stage, after three front stages for products,
// sums and range check, and is followed by one output stage. Write conj_mode
// and epsilon only while no transaction is in flight.
`include "complex_spectrum_divide_top_defines.svh"

module complex_spectrum_divide_top #(
    parameter int SAMPLE_WIDTH  = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  csd_pkg::t_in_item           i_cmd,
    output logic                        o_done,
    output csd_pkg::t_out_item          o_result,
    input  logic                        i_wr_en,
    input  logic [csd_pkg::IDX_W-1:0]   i_wr_index,
    input  logic [csd_pkg::FIELD_W-1:0] i_wr_data
);
    localparam int SW  = SAMPLE_WIDTH;
    localparam int DW  = 2 * SW + 1;
    localparam int LAT = SW + 4;

    logic                     r_conj_mode;
    logic [csd_pkg::EPS_W-1:0] r_epsilon;

    logic            w_valid [0:SW];
    csd_pkg::t_flags w_flags [0:SW];
    logic [DW-1:0]   w_den   [0:SW];
    logic [DW-1:0]   w_rem_re[0:SW];
    logic [DW-1:0]   w_rem_im[0:SW];
    logic [SW-1:0]   w_low_re[0:SW];
    logic [SW-1:0]   w_low_im[0:SW];
    logic [SW-1:0]   w_q_re  [0:SW];
    logic [SW-1:0]   w_q_im  [0:SW];

    logic [SW:0]     fx_re, fx_im;
    logic            r_ro_out;

    function automatic logic [SW:0] fix_part(input logic [SW-1:0] q, input logic neg,
                                            input logic nneg, input logic dz,
                                            input logic nz, input logic ovf);
        logic [SW-1:0] pos_lim;
        logic [SW-1:0] neg_lim;
        logic [SW-1:0] lim;
        logic [SW-1:0] m;
        logic [SW-1:0] v;
        logic          sat;
        pos_lim = {1'b0, {(SW-1){1'b1}}};
        neg_lim = {1'b1, {(SW-1){1'b0}}};
        lim     = neg ? neg_lim : pos_lim;
        if (dz) begin
            sat = 1'b1;
            v   = nz ? '0 : (nneg ? neg_lim : pos_lim);
        end else if (nz) begin
            sat = 1'b0;
            v   = '0;
        end else begin
            if (ovf || (q > lim)) begin
                sat = 1'b1;
                m   = lim;
            end else begin
                sat = 1'b0;
                m   = q;
            end
            v = neg ? (~m + 1'b1) : m;
        end
        return {sat, v};
    endfunction

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conj_mode <= 1'b0;
            r_epsilon   <= csd_pkg::EPS_RESET;
        end else if (i_wr_en) begin
            case (i_wr_index)
                csd_pkg::REG_CONJ_MODE: r_conj_mode <= i_wr_data[0];
                csd_pkg::REG_EPSILON:   r_epsilon   <= i_wr_data[csd_pkg::EPS_W-1:0];
                default: ;
            endcase
        end
    end

    csd_front #(.SW(SW), .FB(FRACTION_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy),
        .i_item   (i_cmd),
        .i_conj   (r_conj_mode),
        .i_eps    (r_epsilon),
        .o_valid  (w_valid[0]),
        .o_flags  (w_flags[0]),
        .o_den    (w_den[0]),
        .o_rem_re (w_rem_re[0]),
        .o_rem_im (w_rem_im[0]),
        .o_low_re (w_low_re[0]),
        .o_low_im (w_low_im[0])
    );

    assign w_q_re[0] = '0;
    assign w_q_im[0] = '0;

    for (genvar k = 0; k < SW; k++) begin : g_div
        csd_div_stage #(.SW(SW)) u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (w_valid[k]),
            .i_flags  (w_flags[k]),
            .i_den    (w_den[k]),
            .i_rem_re (w_rem_re[k]),
            .i_rem_im (w_rem_im[k]),
            .i_low_re (w_low_re[k]),
            .i_low_im (w_low_im[k]),
            .i_q_re   (w_q_re[k]),
            .i_q_im   (w_q_im[k]),
            .o_valid  (w_valid[k+1]),
            .o_flags  (w_flags[k+1]),
            .o_den    (w_den[k+1]),
            .o_rem_re (w_rem_re[k+1]),
            .o_rem_im (w_rem_im[k+1]),
            .o_low_re (w_low_re[k+1]),
            .o_low_im (w_low_im[k+1]),
            .o_q_re   (w_q_re[k+1]),
            .o_q_im   (w_q_im[k+1])
        );
    end

    always_comb begin
        fx_re = fix_part(w_q_re[SW], w_flags[SW].neg_re, w_flags[SW].nneg_re,
                         w_flags[SW].den_zero, w_flags[SW].nz_re, w_flags[SW].ovf_re);
        fx_im = fix_part(w_q_im[SW], w_flags[SW].neg_im, w_flags[SW].nneg_im,
                         w_flags[SW].den_zero, w_flags[SW].nz_im, w_flags[SW].ovf_im);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= w_valid[SW];
        end
        r_ro_out        <= w_flags[SW].real_only;
        o_result.q_real <= csd_pkg::FIELD_W'($signed(fx_re[SW-1:0]));
        if (w_flags[SW].real_only) begin
            o_result.q_imag    <= '0;
            o_result.saturated <= fx_re[SW];
        end else begin
            o_result.q_imag    <= csd_pkg::FIELD_W'($signed(fx_im[SW-1:0]));
            o_result.saturated <= fx_re[SW] | fx_im[SW];
        end
    end

    `CSD_ASSERT_IMPLIES(a_latency, o_done, $past(start, LAT))
    `CSD_ASSERT_IMPLIES(a_real_only_imag, o_done && r_ro_out, o_result.q_imag == '0)
    `CSD_ASSERT_NEXT(a_zero_den_sat, w_valid[SW] && w_flags[SW].den_zero, o_result.saturated)

endmodule
